### design/enbid_pkg.sv
package enbid_pkg;

    // note layout
    localparam int HEADER_BYTES = 12;
    localparam int NOTE_ALIGN   = 4;
    localparam int NAME_BYTES   = 4;

    // padded sizes need one bit more than the 32-bit header fields
    localparam int SIZE_W = 33;

    // type of a build id note, as it appears little-endian in the header
    localparam logic [31:0] BUILD_ID_TYPE = 32'd3;

    // "GNU" and its terminating zero, first byte in the low lane
    localparam logic [31:0] GNU_NAME = 32'h00_55_4E_47;

    // result codes
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_NONE  = 2'd2,
        KIND_TRUNC = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  id_byte;
        logic        last;
    } result_t;

endpackage

### design/enbid_parse.sv
module enbid_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                end_of_section,
    output logic                res_valid,
    output enbid_pkg::result_t  res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_DESC,
        PH_SKIP,
        PH_DONE
    } phase_t;

    localparam int SW = enbid_pkg::SIZE_W;
    localparam logic [SW-1:0] ALIGN_ADD  = SW'(enbid_pkg::NOTE_ALIGN - 1);
    localparam logic [SW-1:0] ALIGN_MASK = ~ALIGN_ADD;
    localparam logic [3:0] HDR_LAST   = 4'(enbid_pkg::HEADER_BYTES - 1);
    localparam logic [3:0] TYPE_FIRST = 4'(8);
    localparam logic [3:0] DESC_FIRST = 4'(4);
    localparam logic [2:0] NAME_CMP   = 3'(enbid_pkg::NAME_BYTES);

    phase_t          phase_reg,      phase_next;
    logic [3:0]      hdr_count_reg,  hdr_count_next;
    logic [31:0]     name_raw_reg,   name_raw_next;
    logic [31:0]     desc_raw_reg,   desc_raw_next;
    logic [SW-1:0]   desc_pad_reg,   desc_pad_next;
    logic            type_ok_reg,    type_ok_next;
    logic [SW-1:0]   bytes_left_reg, bytes_left_next;
    logic [2:0]      name_pos_reg,   name_pos_next;
    logic            match_reg,      match_next;

    logic [SW-1:0]   name_pad;
    logic [SW-1:0]   desc_pad_c;
    logic [7:0]      type_byte;
    logic            desc_go;
    logic [SW-1:0]   desc_len;
    logic            match_now;
    logic            closed;
    logic            left_one;

    // padded sizes, valid once the size fields are complete
    assign name_pad   = ({1'b0, name_raw_reg} + ALIGN_ADD) & ALIGN_MASK;
    assign desc_pad_c = ({1'b0, desc_raw_reg} + ALIGN_ADD) & ALIGN_MASK;
    assign type_byte  = enbid_pkg::BUILD_ID_TYPE[8*hdr_count_reg[1:0] +: 8];
    assign left_one   = (bytes_left_reg == SW'(1));

    // per-byte parse step
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_count_next  = hdr_count_reg;
        name_raw_next   = name_raw_reg;
        desc_raw_next   = desc_raw_reg;
        desc_pad_next   = desc_pad_reg;
        type_ok_next    = type_ok_reg;
        bytes_left_next = bytes_left_reg;
        name_pos_next   = name_pos_reg;
        match_next      = match_reg;

        res_valid   = 1'b0;
        res.kind    = enbid_pkg::KIND_BYTE;
        res.id_byte = '0;
        res.last    = 1'b0;

        desc_go   = 1'b0;
        desc_len  = desc_pad_reg;
        match_now = match_reg;
        closed    = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                // assemble the little-endian header fields
                if (hdr_count_reg < DESC_FIRST)
                begin
                    name_raw_next[8*hdr_count_reg[1:0] +: 8] = data_byte;
                end
                else if (hdr_count_reg < TYPE_FIRST)
                begin
                    desc_raw_next[8*hdr_count_reg[1:0] +: 8] = data_byte;
                end
                else
                begin
                    type_ok_next = ((hdr_count_reg == TYPE_FIRST) || type_ok_reg)
                                   && (data_byte == type_byte);
                end

                if (hdr_count_reg == HDR_LAST)
                begin
                    hdr_count_next = '0;
                    desc_pad_next  = desc_pad_c;
                    name_pos_next  = '0;
                    match_now      = type_ok_reg && (data_byte == type_byte)
                                     && (name_pad != '0);
                    match_next     = match_now;
                    if (name_pad != '0)
                    begin
                        bytes_left_next = name_pad;
                        phase_next      = PH_NAME;
                    end
                    else
                    begin
                        desc_go  = 1'b1;
                        desc_len = desc_pad_c;
                    end
                end
                else
                begin
                    hdr_count_next = hdr_count_reg + 4'd1;
                end
            end

            PH_NAME:
            begin
                // compare the leading name bytes against "GNU\0"
                if (name_pos_reg < NAME_CMP)
                begin
                    if (data_byte != enbid_pkg::GNU_NAME[8*name_pos_reg[1:0] +: 8])
                    begin
                        match_now = 1'b0;
                    end
                    name_pos_next = name_pos_reg + 3'd1;
                end
                match_next      = match_now;
                bytes_left_next = bytes_left_reg - SW'(1);
                if (left_one)
                begin
                    desc_go = 1'b1;
                end
            end

            PH_DESC:
            begin
                res_valid       = 1'b1;
                res.id_byte     = data_byte;
                bytes_left_next = bytes_left_reg - SW'(1);
                if (left_one)
                begin
                    res.last   = 1'b1;
                    phase_next = PH_DONE;
                end
            end

            PH_SKIP:
            begin
                bytes_left_next = bytes_left_reg - SW'(1);
                if (left_one)
                begin
                    phase_next = PH_HEADER;
                end
            end

            default:
            begin
                closed = 1'b1;
            end
        endcase

        // name done: start or skip the descriptor, report an empty id, or go to the next header
        if (desc_go)
        begin
            if (match_now && (desc_len == '0))
            begin
                res_valid   = 1'b1;
                res.kind    = enbid_pkg::KIND_EMPTY;
                res.id_byte = '0;
                res.last    = 1'b1;
                phase_next  = PH_DONE;
            end
            else if (desc_len != '0)
            begin
                bytes_left_next = desc_len;
                phase_next      = match_now ? PH_DESC : PH_SKIP;
            end
            else
            begin
                phase_next = PH_HEADER;
            end
        end

        // section end: status result unless the id already closed, then parser reset
        if (end_of_section)
        begin
            if (!closed && (phase_next != PH_DONE))
            begin
                res_valid   = 1'b1;
                res.kind    = ((phase_next == PH_HEADER) && (hdr_count_next == '0))
                              ? enbid_pkg::KIND_NONE : enbid_pkg::KIND_TRUNC;
                res.id_byte = '0;
                res.last    = 1'b1;
            end
            phase_next      = PH_HEADER;
            hdr_count_next  = '0;
            type_ok_next    = 1'b0;
            bytes_left_next = '0;
            name_pos_next   = '0;
            match_next      = 1'b1;
        end
    end

    // parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hdr_count_reg  <= '0;
            bytes_left_reg <= '0;
            name_pos_reg   <= '0;
            match_reg      <= 1'b1;
            type_ok_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            hdr_count_reg  <= hdr_count_next;
            bytes_left_reg <= bytes_left_next;
            name_pos_reg   <= name_pos_next;
            match_reg      <= match_next;
            type_ok_reg    <= type_ok_next;
        end
    end

    // header field capture
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            name_raw_reg <= name_raw_next;
            desc_raw_reg <= desc_raw_next;
            desc_pad_reg <= desc_pad_next;
        end
    end

endmodule

### design/elf_note_build_id_extractor.sv
// Build id extractor for an ELF note section.
// Input channel: one section byte per request on data_byte, with
// end_of_section set on the section's last byte; in_valid / in_stall.
// Output channel: kind, id_byte, last; out_valid / out_stall. Each input
// byte gives zero or one result: id bytes of the first GNU build id note
// (kind 0, last on the final one), or one status result with last set
// (kind 1 empty id, 2 no build id note, 3 section cut off inside a record).
// Bytes after a complete id are dropped up to the section end.
// Each accepted byte is held in the input register; the parse step works
// combinationally from the input register, updates its state and writes
// the result register at the next edge.
// Throughput: one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; the input register
// still takes a byte if it is empty and then raises in_stall until the
// result drains.
// Reset clears both registers' valid flags and returns the parser to the
// start of a section; every end_of_section, after its result, does the latter.
module elf_note_build_id_extractor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               end_of_section,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         id_byte,
    output logic               last
);

    logic                in_valid_reg;
    logic [7:0]          in_data_reg;
    logic                in_eos_reg;
    logic                out_valid_reg;
    enbid_pkg::result_t  out_reg;

    logic                advance;
    logic                step;
    logic                in_take;
    logic                res_valid;
    enbid_pkg::result_t  res;

    // handshake control
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= data_byte;
            in_eos_reg  <= end_of_section;
        end
    end

    // parse step
    enbid_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_byte      (in_data_reg),
        .end_of_section (in_eos_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign id_byte   = out_reg.id_byte;
    assign last      = out_reg.last;

endmodule

### tb/elf_note_build_id_extractor_test.sv
module elf_note_build_id_extractor_test;

    localparam int ITEM_TARGET    = 1000;
    localparam int NOTE_CAP       = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [33:0] ALIGN_MASK = 34'(enbid_pkg::NOTE_ALIGN - 1);

    typedef enum logic [2:0] {
        AT_HEADER,
        AT_NAME,
        AT_DESC,
        AT_SKIP,
        AT_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] value;
        logic       closes;
    } section_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'd0;
    logic       end_of_section = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] id_byte;
    logic       last;

    // section bytes waiting to be sent, and id results still to arrive
    section_byte_t        pending_bytes[$];
    enbid_pkg::result_t   id_expected[$];
    logic [7:0]           section_bytes[$];

    section_byte_t        next_req;
    enbid_pkg::result_t   upcoming;
    enbid_pkg::result_t   want;
    int            errors = 0;
    int            quiet_cycles;
    int            cycle_no;
    logic          calm;

    // parser state of the predictor
    parse_phase_t ph;
    logic [3:0]   hdr_cnt;
    logic [33:0]  nm_size;
    logic [33:0]  ds_size;
    logic [33:0]  remaining;
    logic [31:0]  nt_type;
    logic         match_ok;
    logic         id_done;

    elf_note_build_id_extractor dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_section (end_of_section),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .id_byte        (id_byte),
        .last           (last)
    );

    always #2 clk = ~clk;

    function automatic logic [33:0] pad_up(input logic [33:0] n);
        return (n + ALIGN_MASK) & ~ALIGN_MASK;
    endfunction

    function automatic void clear_parser();
        ph        = AT_HEADER;
        hdr_cnt   = 4'd0;
        nm_size   = 34'd0;
        ds_size   = 34'd0;
        nt_type   = 32'd0;
        remaining = 34'd0;
        match_ok  = 1'b1;
        id_done   = 1'b0;
    endfunction

    // name consumed: empty id, descriptor, skip or next header
    function automatic bit open_descriptor(output enbid_pkg::result_t r);
        bit got;
        got       = 1'b0;
        r.kind    = enbid_pkg::KIND_BYTE;
        r.id_byte = 8'd0;
        r.last    = 1'b0;
        if (match_ok && ds_size == 34'd0)
        begin
            r.kind  = enbid_pkg::KIND_EMPTY;
            r.last  = 1'b1;
            id_done = 1'b1;
            ph      = AT_DONE;
            got     = 1'b1;
        end
        else if (ds_size != 34'd0)
        begin
            remaining = ds_size;
            ph        = match_ok ? AT_DESC : AT_SKIP;
        end
        else
            ph = AT_HEADER;
        return got;
    endfunction

    // one section byte in, at most one result out
    function automatic bit predict_request(input logic [7:0] b, input logic eos,
                                           output enbid_pkg::result_t r);
        logic [33:0] idx;
        bit          got;
        bit          closed;
        bit          clean;
        got       = 1'b0;
        closed    = 1'b0;
        r.kind    = enbid_pkg::KIND_BYTE;
        r.id_byte = 8'd0;
        r.last    = 1'b0;
        case (ph)
            AT_HEADER:
            begin
                if (hdr_cnt == 4'd0)
                begin
                    nm_size = 34'd0;
                    ds_size = 34'd0;
                    nt_type = 32'd0;
                end
                // little-endian fields, one lane per byte
                if (hdr_cnt < 4)
                    nm_size[8*hdr_cnt[1:0] +: 8] = b;
                else if (hdr_cnt < 8)
                    ds_size[8*hdr_cnt[1:0] +: 8] = b;
                else
                    nt_type[8*hdr_cnt[1:0] +: 8] = b;
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt >= enbid_pkg::HEADER_BYTES)
                begin
                    hdr_cnt  = 4'd0;
                    nm_size  = pad_up(nm_size);
                    ds_size  = pad_up(ds_size);
                    match_ok = (nt_type == enbid_pkg::BUILD_ID_TYPE) && (nm_size != 34'd0);
                    if (nm_size != 34'd0)
                    begin
                        remaining = nm_size;
                        ph        = AT_NAME;
                    end
                    else
                        got = open_descriptor(r);
                end
            end
            AT_NAME:
            begin
                // only the first four name bytes count
                idx = nm_size - remaining;
                if (idx < enbid_pkg::NAME_BYTES
                    && b != enbid_pkg::GNU_NAME[8*idx[1:0] +: 8])
                    match_ok = 1'b0;
                if (remaining != 34'd0)
                    remaining = remaining - 34'd1;
                if (remaining == 34'd0)
                    got = open_descriptor(r);
            end
            AT_DESC:
            begin
                if (remaining != 34'd0)
                    remaining = remaining - 34'd1;
                r.kind    = enbid_pkg::KIND_BYTE;
                r.id_byte = b;
                r.last    = (remaining == 34'd0);
                if (remaining == 34'd0)
                begin
                    id_done = 1'b1;
                    ph      = AT_DONE;
                end
                got = 1'b1;
            end
            AT_SKIP:
            begin
                if (remaining != 34'd0)
                    remaining = remaining - 34'd1;
                if (remaining == 34'd0)
                    ph = AT_HEADER;
            end
            default:
                closed = 1'b1;
        endcase
        // section end with no id yet: clean miss or cut-off record
        if (!closed && !id_done && eos)
        begin
            clean     = (ph == AT_HEADER) && (hdr_cnt == 4'd0);
            r.kind    = clean ? enbid_pkg::KIND_NONE : enbid_pkg::KIND_TRUNC;
            r.id_byte = 8'd0;
            r.last    = 1'b1;
            got       = 1'b1;
        end
        if (eos)
            clear_parser();
        return got;
    endfunction

    // header, padded name and padded descriptor, long ones cut short
    task automatic add_note(input logic [31:0] name_field, input logic [31:0] desc_field,
                            input logic [31:0] type_field, input logic [31:0] name_word,
                            input int fill);
        logic [33:0] name_len;
        logic [33:0] desc_len;
        for (int i = 0; i < 4; i++)
            section_bytes.push_back(name_field[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            section_bytes.push_back(desc_field[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            section_bytes.push_back(type_field[8*i +: 8]);
        name_len = pad_up({2'b00, name_field});
        desc_len = pad_up({2'b00, desc_field});
        if (name_len > NOTE_CAP)
            name_len = 34'(NOTE_CAP);
        if (desc_len > NOTE_CAP)
            desc_len = 34'(NOTE_CAP);
        for (int i = 0; i < name_len; i++)
        begin
            if (i < enbid_pkg::NAME_BYTES)
                section_bytes.push_back(name_word[8*i +: 8]);
            else
                section_bytes.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < desc_len; i++)
        begin
            if (fill < 0)
                section_bytes.push_back(8'($urandom_range(0, 255)));
            else
                section_bytes.push_back(fill[7:0]);
        end
    endtask

    // queue the section, keeping only the first keep bytes when keep > 0
    task automatic close_section(input int keep);
        section_byte_t item;
        int            n;
        if (section_bytes.size() == 0)
            section_bytes.push_back(8'($urandom_range(0, 255)));
        n = section_bytes.size();
        if (keep > 0 && keep < n)
            n = keep;
        for (int i = 0; i < n; i++)
        begin
            item.value  = section_bytes[i];
            item.closes = (i == n - 1);
            pending_bytes.push_back(item);
        end
        section_bytes.delete();
    endtask

    function automatic bit take_break();
        return !calm && $urandom_range(0, 99) < 8;
    endfunction

    assign calm = (cycle_no >= 300) && (cycle_no < 900);

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            data_byte      <= 8'd0;
            end_of_section <= 1'b0;
        end
        else
        begin
            // predict the request taken at this edge
            if (in_valid && !in_stall)
            begin
                if (predict_request(data_byte, end_of_section, upcoming))
                    id_expected.push_back(upcoming);
            end
            // next request, unless the current one is held
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && !take_break())
                begin
                    next_req = pending_bytes.pop_front();
                    in_valid       <= 1'b1;
                    data_byte      <= next_req.value;
                    end_of_section <= next_req.closes;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (id_expected.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d id_byte %02h last %0b",
                             $time, kind, id_byte, last);
                    errors = errors + 1;
                end
                else
                begin
                    want = id_expected.pop_front();
                    if (kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
                        errors = errors + 1;
                    end
                    if (id_byte !== want.id_byte)
                    begin
                        $display("%0t: id_byte expected %02h actual %02h",
                                 $time, want.id_byte, id_byte);
                        errors = errors + 1;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                        errors = errors + 1;
                    end
                end
            end
            out_stall <= take_break();
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
            cycle_no     <= 0;
        end
        else
        begin
            cycle_no <= cycle_no + 1;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int style;
        clear_parser();

        // complete id of all-ones bytes, then a byte that is dropped
        add_note(32'd4, 32'd4, enbid_pkg::BUILD_ID_TYPE, enbid_pkg::GNU_NAME, 8'hFF);
        section_bytes.push_back(8'h00);
        close_section(0);
        // empty id, name size padded up from three
        add_note(32'd3, 32'd0, enbid_pkg::BUILD_ID_TYPE, enbid_pkg::GNU_NAME, 0);
        close_section(0);
        // zero name size never matches, section ends on a record boundary
        add_note(32'd0, 32'd0, enbid_pkg::BUILD_ID_TYPE, enbid_pkg::GNU_NAME, 0);
        close_section(0);
        // long name, padded descriptor of zero bytes
        add_note(32'd8, 32'd2, enbid_pkg::BUILD_ID_TYPE, enbid_pkg::GNU_NAME, 8'h00);
        close_section(0);
        // cut inside the header, then inside the name
        add_note(32'd4, 32'd4, enbid_pkg::BUILD_ID_TYPE, enbid_pkg::GNU_NAME, -1);
        close_section(5);
        add_note(32'd4, 32'd4, enbid_pkg::BUILD_ID_TYPE, enbid_pkg::GNU_NAME, -1);
        close_section(14);
        // oversized descriptor, then largest name size
        add_note(32'd4, 32'hFFFF_FFFF, enbid_pkg::BUILD_ID_TYPE, enbid_pkg::GNU_NAME, -1);
        close_section(0);
        add_note(32'hFFFF_FFFF, 32'd0, enbid_pkg::BUILD_ID_TYPE, enbid_pkg::GNU_NAME, -1);
        close_section(0);
        // one-byte section
        section_bytes.push_back(8'hFF);
        close_section(0);

        // random sections, mostly well-formed notes
        while (pending_bytes.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                repeat ($urandom_range(1, 30))
                    section_bytes.push_back(8'($urandom_range(0, 255)));
                close_section(0);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    style = $urandom_range(0, 99);
                    if (style < 50)
                        add_note($urandom_range(1, 8), $urandom_range(0, 20),
                                 enbid_pkg::BUILD_ID_TYPE,
                                 ($urandom_range(0, 4) == 0) ?
                                     enbid_pkg::GNU_NAME ^ (32'd1 << $urandom_range(0, 31))
                                     : enbid_pkg::GNU_NAME,
                                 -1);
                    else if (style < 92)
                        add_note($urandom_range(0, 12), $urandom_range(0, 16),
                                 $urandom_range(0, 5), $urandom(), -1);
                    else
                        add_note($urandom(), $urandom(),
                                 ($urandom_range(0, 1) == 1) ?
                                     enbid_pkg::BUILD_ID_TYPE : $urandom(),
                                 enbid_pkg::GNU_NAME, -1);
                end
                if ($urandom_range(0, 4) == 0)
                    close_section($urandom_range(1, section_bytes.size()));
                else
                    close_section(0);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || in_valid || id_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && id_expected.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
